// File: rtl/bsm_pkg.sv
// bsm_pkg: types and constants shared by the bounding sphere merge block
// fixed field widths of the sphere and bound beats, derived arithmetic widths
// no dependencies
package bsm_pkg;

	localparam int CW = 32;          // coordinate width
	localparam int RW = CW - 1;      // radius width
	localparam int DW = CW + 1;      // distance / shift width
	localparam int PW = DW + CW;     // product width
	localparam int SW = 2 * CW + 2;  // squared distance width (even)

	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic signed [CW-1:0] sphere_x;
		logic signed [CW-1:0] sphere_y;
		logic signed [CW-1:0] sphere_z;
		logic [RW-1:0]        sphere_radius;
	} sphere_t;

	typedef struct packed {
		logic signed [CW-1:0] bound_x;
		logic signed [CW-1:0] bound_y;
		logic signed [CW-1:0] bound_z;
		logic [RW-1:0]        bound_r;
		logic                 saturated;
	} bound_t;

endpackage

// File: rtl/bsm_sqrt.sv
// bsm_sqrt: iterative floor square root, two radicand bits per cycle
// depends on bsm_pkg
module bsm_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [bsm_pkg::SW-1:0]  radicand,
	output logic                    done,
	output logic [bsm_pkg::DW-1:0]  root
);
	import bsm_pkg::*;

	localparam int CNTW = $clog2(DW + 1);

	logic [SW-1:0]   rad_q;
	logic [DW:0]     rem_q;
	logic [DW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;

	logic [DW+1:0] rem_sh;
	logic [DW+1:0] trial;
	logic          take;

	assign rem_sh = {rem_q[DW-1:0], rad_q[SW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNTW'(DW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNTW'(DW - 1)) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[SW-3:0], 2'b00};
			if (take) begin
				rem_q  <= (DW+1)'(rem_sh - trial);
				root_q <= {root_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[DW:0];
				root_q <= {root_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/bsm_div.sv
// bsm_div: iterative restoring divider, one quotient bit per cycle
// quotient is known to fit CW bits; depends on bsm_pkg
module bsm_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [bsm_pkg::PW-1:0]  num,
	input  logic [bsm_pkg::DW-1:0]  den,
	output logic                    done,
	output logic [bsm_pkg::CW-1:0]  quo
);
	import bsm_pkg::*;

	localparam int CNTW = $clog2(CW + 1);

	logic [DW-1:0]   rem_q;
	logic [CW-1:0]   low_q;
	logic [CW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;

	logic [DW:0] t;
	logic        take;

	assign t    = {rem_q, low_q[CW-1]};
	assign take = (t >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNTW'(CW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNTW'(CW - 1)) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// high part starts below den, so only the low CW bits yield quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[PW-1:CW];
			low_q <= num[CW-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			low_q <= {low_q[CW-2:0], 1'b0};
			if (take) begin
				rem_q <= DW'(t - {1'b0, den_q});
				quo_q <= {quo_q[CW-2:0], 1'b1};
			end else begin
				rem_q <= t[DW-1:0];
				quo_q <= {quo_q[CW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/bounding_sphere_merge.sv
// bounding_sphere_merge: running bounding sphere over a stream of spheres
// sequencer with one shared multiplier, uses bsm_sqrt, bsm_div and bsm_pkg
//
// usage:
//   sphere channel (sphere_valid / sphere_stall / sphere) takes one command
//   beat: cmd clear empties the bound, cmd add merges one sphere.
//   bound channel (bound_valid / bound_stall / bound) gives one beat per
//   command: the bound as it stands afterward and a saturation flag.
// sequence after acceptance:
//   clear or first add: the bound beat is offered in the next cycle.
//   contained or containing sphere, coincident centers: the squared distance is
//   summed and its square root taken, then the bound beat is offered.
//   full merge: after that, per axis one multiply and one divide, then the
//   bound beat is offered.
// flow control: one command at a time; the next sphere beat can be accepted
//   in the cycle after the bound beat is taken.
//   sphere_stall is high from the cycle after acceptance through the cycle
//   in which the bound beat is taken.
// reset: bound empty, center and radius zero, no beat pending.
// receiver stall: the result beat holds steady until taken, and no new
//   sphere beat is accepted meanwhile.
module bounding_sphere_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sphere_valid,
	output logic             sphere_stall,
	input  bsm_pkg::sphere_t sphere,
	output logic             bound_valid,
	input  logic             bound_stall,
	output bsm_pkg::bound_t  bound
);
	import bsm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_ROOT = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic [RW-1:0] RMAX = '1;
	localparam logic signed [CW:0] CMAX = (CW+1)'((64'd1 << (CW - 1)) - 1);
	localparam logic signed [CW:0] CMIN = -CMAX - 1;

	logic [2:0]           state_q;
	logic                 ok_q;
	logic signed [CW-1:0] cen_q [3];
	logic [RW-1:0]        rad_q;
	logic signed [CW-1:0] c2_q [3];
	logic [RW-1:0]        r2_q;
	logic [CW-1:0]        mag_q [3];
	logic [2:0]           neg_q;
	logic [1:0]           cnt_q;
	logic [SW-1:0]        sum_q;
	logic [PW-1:0]        prod_q;
	logic [DW-1:0]        d_q;
	logic [DW-1:0]        shift_q;
	logic                 sat_q;
	logic                 sq_go_q;
	logic                 dv_go_q;

	logic                 accept;
	logic signed [CW-1:0] in_c [3];
	logic signed [CW:0]   dfull [3];
	logic [CW-1:0]        mul_b;
	logic [DW-1:0]        mul_a;
	logic [PW-1:0]        mul_p;
	logic                 root_done;
	logic [DW-1:0]        root;
	logic                 div_done;
	logic [CW-1:0]        quo;
	logic [DW:0]          dr2, dr1, big2;
	logic [DW-1:0]        big;
	logic signed [CW+1:0] cnew;
	logic signed [CW+1:0] cext;
	logic signed [CW+1:0] qext;

	assign accept = sphere_valid && !sphere_stall;
	assign sphere_stall = (state_q != S_IDLE);
	assign in_c[0] = sphere.sphere_x;
	assign in_c[1] = sphere.sphere_y;
	assign in_c[2] = sphere.sphere_z;

	for (genvar g = 0; g < 3; g++) begin : g_delta
		assign dfull[g] = {in_c[g][CW-1], in_c[g]} - {cen_q[g][CW-1], cen_q[g]};
	end

	// shared multiplier operand select
	always_comb begin
		case (cnt_q)
			2'd0:    mul_b = mag_q[0];
			2'd1:    mul_b = mag_q[1];
			2'd2:    mul_b = mag_q[2];
			default: mul_b = '0;
		endcase
		if (state_q == S_SQ) begin
			mul_a = {1'b0, mul_b};
		end else begin
			mul_a = shift_q;
		end
	end

	assign mul_p = mul_a * mul_b;

	assign dr2  = {1'b0, root} + (DW+1)'(r2_q);
	assign dr1  = {1'b0, root} + (DW+1)'(rad_q);
	assign big2 = dr1 + (DW+1)'(r2_q);
	assign big  = big2[DW:1];

	assign cext = (CW+2)'(cen_q[cnt_q]);
	assign qext = (CW+2)'({1'b0, quo});
	assign cnew = neg_q[cnt_q] ? (cext - qext) : (cext + qext);

	bsm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_go_q),
		.radicand (sum_q),
		.done     (root_done),
		.root     (root)
	);

	bsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_go_q),
		.num    (prod_q),
		.den    (d_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
			cen_q   <= '{default: '0};
			rad_q   <= '0;
			sat_q   <= 1'b0;
			cnt_q   <= '0;
			sq_go_q <= 1'b0;
			dv_go_q <= 1'b0;
		end else begin
			sq_go_q <= (state_q == S_SQ) && (cnt_q == 2'd3);
			dv_go_q <= (state_q == S_MUL);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sat_q <= 1'b0;
						if (sphere.cmd == CMD_CLEAR) begin
							ok_q    <= 1'b0;
							cen_q   <= '{default: '0};
							rad_q   <= '0;
							state_q <= S_OUT;
						end else if (!ok_q) begin
							ok_q    <= 1'b1;
							cen_q   <= in_c;
							rad_q   <= sphere.sphere_radius;
							state_q <= S_OUT;
						end else begin
							cnt_q   <= '0;
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (root_done) begin
						if (dr2 < (DW+1)'(rad_q)) begin
							state_q <= S_OUT;
						end else if (dr1 < (DW+1)'(r2_q)) begin
							cen_q   <= c2_q;
							rad_q   <= r2_q;
							state_q <= S_OUT;
						end else begin
							if (big > DW'(RMAX)) begin
								rad_q <= RMAX;
								sat_q <= 1'b1;
							end else begin
								rad_q <= big[RW-1:0];
							end
							cnt_q <= '0;
							if (root == '0) begin
								state_q <= S_OUT;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (cnew > (CW+2)'(CMAX)) begin
							cen_q[cnt_q] <= CMAX[CW-1:0];
							sat_q        <= 1'b1;
						end else if (cnew < (CW+2)'(CMIN)) begin
							cen_q[cnt_q] <= CMIN[CW-1:0];
							sat_q        <= 1'b1;
						end else begin
							cen_q[cnt_q] <= cnew[CW-1:0];
						end
						if (cnt_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_OUT: begin
					if (!bound_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == S_IDLE && accept) begin
			c2_q <= in_c;
			r2_q <= sphere.sphere_radius;
			sum_q <= '0;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= dfull[i][CW];
				mag_q[i] <= dfull[i][CW] ? CW'(-dfull[i]) : dfull[i][CW-1:0];
			end
		end
		if (state_q == S_SQ && cnt_q != 2'd0) begin
			sum_q <= sum_q + SW'(prod_q);
		end
		if (state_q == S_ROOT && root_done) begin
			d_q     <= root;
			shift_q <= DW'(big - DW'(rad_q));
		end
	end

	assign bound_valid     = (state_q == S_OUT);
	assign bound.bound_x   = cen_q[0];
	assign bound.bound_y   = cen_q[1];
	assign bound.bound_z   = cen_q[2];
	assign bound.bound_r   = rad_q;
	assign bound.saturated = sat_q;

endmodule

// File: tb/sv/bsm_checker.sv
// bsm_checker: watches the sphere and bound channels of bounding_sphere_merge
// predicts each bound beat from its own copy of the running sphere, counts mismatches
// depends on bsm_pkg
module bsm_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sphere_valid,
	input  logic             sphere_stall,
	input  bsm_pkg::sphere_t sphere,
	input  logic             bound_valid,
	input  logic             bound_stall,
	input  bsm_pkg::bound_t  bound,
	output int               fail_count,
	output int               pending
);
	import bsm_pkg::*;

	localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;
	localparam logic signed [63:0] RAD_MAX   = 64'sd2147483647;

	logic                have_bound;
	logic signed [63:0]  ctr [3];
	logic signed [63:0]  rad;
	bound_t              expected_bounds [$];

	function automatic logic [63:0] isqrt(input logic [127:0] n);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= n)
				res = cand;
		end
		return res;
	endfunction

	task automatic merge_sphere(input sphere_t s, output bound_t o);
		logic signed [63:0]  c2 [3];
		logic signed [63:0]  dl [3];
		logic signed [63:0]  r2, d, big_r, shift, off, c;
		logic [127:0]        sq, prod;
		logic [63:0]         mag;
		logic                sat;
		sat = 1'b0;
		c2[0] = s.sphere_x;
		c2[1] = s.sphere_y;
		c2[2] = s.sphere_z;
		r2 = {33'd0, s.sphere_radius};
		if (s.cmd == CMD_CLEAR) begin
			have_bound = 1'b0;
			foreach (ctr[i]) ctr[i] = 0;
			rad = 0;
		end else if (!have_bound) begin
			foreach (ctr[i]) ctr[i] = c2[i];
			rad = r2;
			have_bound = 1'b1;
		end else begin
			sq = '0;
			for (int i = 0; i < 3; i++) begin
				dl[i] = c2[i] - ctr[i];
				mag = dl[i] < 0 ? -dl[i] : dl[i];
				sq += {64'd0, mag} * {64'd0, mag};
			end
			d = isqrt(sq);
			if (d + r2 < rad) begin
				// contained, bound unchanged
			end else if (d + rad < r2) begin
				foreach (ctr[i]) ctr[i] = c2[i];
				rad = r2;
			end else begin
				big_r = (d + rad + r2) / 2;
				shift = big_r - rad;
				if (d != 0) begin
					for (int i = 0; i < 3; i++) begin
						mag = dl[i] < 0 ? -dl[i] : dl[i];
						prod = ({64'd0, shift} * {64'd0, mag}) / {64'd0, d};
						off = {2'b00, prod[61:0]};
						c = ctr[i] + (dl[i] < 0 ? -off : off);
						if (c > COORD_MAX) begin
							c = COORD_MAX;
							sat = 1'b1;
						end
						if (c < COORD_MIN) begin
							c = COORD_MIN;
							sat = 1'b1;
						end
						ctr[i] = c;
					end
				end
				if (big_r > RAD_MAX) begin
					big_r = RAD_MAX;
					sat = 1'b1;
				end
				rad = big_r;
			end
		end
		o.bound_x = ctr[0][31:0];
		o.bound_y = ctr[1][31:0];
		o.bound_z = ctr[2][31:0];
		o.bound_r = rad[30:0];
		o.saturated = sat;
	endtask

	assign pending = expected_bounds.size();

	always @(posedge clk or negedge arst_n) begin
		bound_t want;
		if (!arst_n) begin
			have_bound = 1'b0;
			foreach (ctr[i]) ctr[i] = 0;
			rad = 0;
			fail_count = 0;
			expected_bounds.delete();
		end else begin
			if (bound_valid && !bound_stall) begin
				if (expected_bounds.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected bound beat %h", bound);
				end else begin
					want = expected_bounds.pop_front();
					if (want.bound_x !== bound.bound_x || want.bound_y !== bound.bound_y ||
							want.bound_z !== bound.bound_z || want.bound_r !== bound.bound_r ||
							want.saturated !== bound.saturated) begin
						fail_count++;
						if (fail_count <= 10)
							$display("bound mismatch: exp x=%h y=%h z=%h r=%h s=%b got x=%h y=%h z=%h r=%h s=%b",
								want.bound_x, want.bound_y, want.bound_z, want.bound_r,
								want.saturated, bound.bound_x, bound.bound_y,
								bound.bound_z, bound.bound_r, bound.saturated);
					end
				end
			end
			if (sphere_valid && !sphere_stall) begin
				merge_sphere(sphere, want);
				expected_bounds.push_back(want);
			end
		end
	end
endmodule

// File: tb/sv/testbench.sv
// testbench: drives sphere commands into bounding_sphere_merge and gives the verdict
// depends on bsm_pkg, bounding_sphere_merge and bsm_checker
module testbench;
	import bsm_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic     clk;
	logic     arst_n;
	logic     sphere_valid;
	logic     sphere_stall;
	sphere_t  sphere;
	logic     bound_valid;
	logic     bound_stall;
	bound_t   bound;
	int       fail_count;
	int       pending;
	int       idle_cycles;
	int       stall_mode;

	bounding_sphere_merge uut (
		.clk(clk), .arst_n(arst_n),
		.sphere_valid(sphere_valid), .sphere_stall(sphere_stall), .sphere(sphere),
		.bound_valid(bound_valid), .bound_stall(bound_stall), .bound(bound)
	);

	bsm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.sphere_valid(sphere_valid), .sphere_stall(sphere_stall), .sphere(sphere),
		.bound_valid(bound_valid), .bound_stall(bound_stall), .bound(bound),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((sphere_valid && !sphere_stall) || (bound_valid && !bound_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver stall pattern: phases of none, light, heavy stalling
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: bound_stall <= 1'b0;
			1: bound_stall <= ($urandom_range(0, 3) == 0);
			default: bound_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send(input logic c, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [30:0] r);
		sphere <= '{cmd: c, sphere_x: x, sphere_y: y, sphere_z: z, sphere_radius: r};
		sphere_valid <= 1'b1;
		@(posedge clk);
		while (sphere_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic gap();
		sphere_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// coordinates mostly near a small cluster, sometimes across the full range
	function automatic logic [31:0] pick_coord(input int span);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	function automatic logic [30:0] pick_radius(input int span);
		case ($urandom_range(0, 9))
			0: return 31'($urandom);
			1: return 31'h7fffffff;
			2: return 31'd0;
			default: return 31'($urandom_range(0, span));
		endcase
	endfunction

	initial begin
		int burst;
		int span;
		int sent;
		logic [31:0] ax, ay, az;
		arst_n = 1'b0;
		sphere_valid = 1'b0;
		sphere = '0;
		bound_stall = 1'b0;
		stall_mode = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, first add, contained, containing, coincident, overflow
		send(CMD_ADD, 32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff);
		send(CMD_ADD, 32'h80000000, 32'h7fffffff, 32'hffffffff, 31'h7fffffff);
		send(CMD_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
		send(CMD_ADD, 32'h0, 32'h0, 32'h0, 31'h00010000);
		send(CMD_ADD, 32'h100, 32'h0, 32'h0, 31'h10);
		send(CMD_ADD, 32'h0, 32'h0, 32'h0, 31'h00100000);
		send(CMD_ADD, 32'h0, 32'h0, 32'h0, 31'h00100000);
		send(CMD_ADD, 32'h0, 32'h0, 32'h0, 31'h00200000);
		send(CMD_ADD, 32'h00400000, 32'hffc00000, 32'h00010000, 31'h00080000);
		gap();
		send(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 31'h0);
		send(CMD_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 31'h40000000);
		send(CMD_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h40000000);
		send(CMD_ADD, 32'h12345678, 32'hedcba987, 32'h55555555, 31'h2aaaaaaa);
		send(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 31'h0);
		send(CMD_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 31'h0);
		send(CMD_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 31'h0);
		send(CMD_ADD, 32'hfffe0000, 32'h00020000, 32'h00030000, 31'h1);
		send(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 31'h0);
		sphere_valid <= 1'b0;

		// random: clears then runs of adds, each run in its own scale
		sent = 18;
		while (sent < 1950) begin
			span = 1 << $urandom_range(4, 30);
			ax = $urandom_range(0, 2 * span) - span;
			ay = $urandom_range(0, 2 * span) - span;
			az = $urandom_range(0, 2 * span) - span;
			send(CMD_CLEAR, $urandom, $urandom, $urandom, 31'($urandom));
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				if ($urandom_range(0, 4) == 0)
					send(CMD_ADD, ax, ay, az, pick_radius(span));
				else
					send(CMD_ADD, ax + pick_coord(span), ay + pick_coord(span),
						az + pick_coord(span), pick_radius(span));
				if ($urandom_range(0, 3) == 0)
					gap();
			end
			sent += burst + 1;
			if ($urandom_range(0, 1) == 0)
				gap();
		end
		sphere_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
